@@ hdl/fnbs_pkg.sv @@
`default_nettype none

package fnbs_pkg;

  localparam int OFFSET_W = 20;

  localparam logic [3:0]  DATA_PAGE      = 4'h9;
  localparam logic [23:0] CMD_ADDR_ONE   = 24'h815554;
  localparam logic [23:0] CMD_ADDR_TWO   = 24'h80AAA8;
  localparam logic [23:0] ID_MANUF_ADDR  = 24'h800000;
  localparam logic [23:0] ID_DEVICE_ADDR = 24'h800004;

  localparam logic [15:0] UNLOCK_FIRST  = 16'h00AA;
  localparam logic [15:0] UNLOCK_SECOND = 16'h0055;
  localparam logic [15:0] CMD_CODE_ID   = 16'h0090;
  localparam logic [15:0] CMD_CODE_WREN = 16'h00A0;
  localparam logic [15:0] MANUF_ID      = 16'h001F;
  localparam logic [15:0] DEVICE_ID     = 16'h00D5;
  localparam logic [15:0] PROBE_WORD    = 16'h0055;
  localparam logic [15:0] ERASED_WORD   = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_ID   = 2'd1,
    CMD_WREN = 2'd2
  } cmd_mode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_AA   = 2'd1,
    PH_55   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic        is_write;
    logic        is_byte;
    logic [23:0] addr;
    logic [15:0] data;
  } req_t;

  typedef struct packed {
    logic        claimed;
    logic        in_window;
    logic        store_wr;
    logic [15:0] word;
    logic [15:0] wdata;
  } resp_t;

endpackage

`default_nettype wire

@@ hdl/flash_nvram_bus_slave_top.sv @@
// Channel | Dir | Signals                   | Contents (lowest bit up)
// s_axis  | in  | tvalid tready tdata tuser | tdata: bus_address, write_value;
//         |     |                           | tuser: mode, byte_size
// m_axis  | out | tvalid tready tdata tuser | tdata: read_value; tuser: claimed, stored
//
// One item at a time: a new item is accepted only after the last one is written back,
// having passed the three-stage index unit followed by one store read and write-back.
// The result waits in an output register.
// After reset the store is swept to all ones;
// tready stays low while the sweep runs.
// A stalled output holds the item in the write-back state until taken.
`default_nettype none

module flash_nvram_bus_slave_top #(
  parameter int unsigned STORE_BYTES = 131072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // bus_address[23:0], write_value[39:24]
  input  logic [1:0]  s_axis_tuser,   // mode[0], byte_size[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // read_value[15:0]
  output logic [1:0]  m_axis_tuser    // claimed[0], stored[1]
);
  import fnbs_pkg::*;

  localparam int AW = $clog2(STORE_BYTES / 2);

  fsm_e        state_q, state_d;
  req_t        req_q;
  resp_t       resp;
  logic        accept;
  logic        idx_done;
  logic [AW-1:0] idx;
  logic        rd_en;
  logic [15:0] rd_data;
  logic        wr_en;
  logic [15:0] wr_data;
  logic        clr_busy;
  logic        commit;
  logic        out_free;
  logic        out_valid_q;
  logic [15:0] out_data_q, out_data_d;
  logic [1:0]  out_user_q;
  logic [15:0] word;
  logic        odd;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign odd      = req_q.addr[0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.is_write <= s_axis_tuser[0];
      req_q.is_byte  <= s_axis_tuser[1];
      req_q.addr     <= s_axis_tdata[23:0];
      req_q.data     <= s_axis_tdata[39:24];
    end
  end

  fnbs_idx #(.STORE_BYTES(STORE_BYTES)) u_idx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .off_i   ({s_axis_tdata[OFFSET_W-1:1], 1'b0}),
    .done_o  (idx_done),
    .idx_o   (idx)
  );

  fnbs_store #(.STORE_BYTES(STORE_BYTES)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx),
    .wr_data_i (wr_data),
    .busy_o    (clr_busy)
  );

  fnbs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .req_i    (req_q),
    .resp_o   (resp)
  );

  assign word = resp.in_window ? rd_data : resp.word;

  always_comb begin
    if (req_q.is_write) begin
      out_data_d = '0;
    end else if (req_q.is_byte) begin
      out_data_d = odd ? {8'h00, word[7:0]} : {8'h00, word[15:8]};
    end else begin
      out_data_d = word;
    end
  end

  always_comb begin
    if (!req_q.is_byte) begin
      wr_data = resp.wdata;
    end else if (odd) begin
      wr_data = {rd_data[15:8], resp.wdata[7:0]};
    end else begin
      wr_data = {resp.wdata[7:0], rd_data[7:0]};
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    commit        = 1'b0;
    wr_en         = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (!clr_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (idx_done) begin
          rd_en   = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          commit  = 1'b1;
          wr_en   = resp.store_wr;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= out_data_d;
      out_user_q <= {resp.store_wr, resp.claimed};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !clr_busy)
    else $error("item accepted during store sweep");

  a_no_write_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (!clr_busy && state_q == ST_DONE))
    else $error("store write outside write-back");

  a_stored_claimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
    else $error("stored item not claimed");

  a_index_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_done |-> (state_q == ST_INDEX))
    else $error("index ready outside index wait");

endmodule

`default_nettype wire

@@ hdl/fnbs_idx.sv @@
`default_nettype none

module fnbs_idx #(
  parameter int unsigned STORE_BYTES = 131072
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [fnbs_pkg::OFFSET_W-1:0]       off_i,
  output logic                                done_o,
  output logic [$clog2(STORE_BYTES/2)-1:0]    idx_o
);
  import fnbs_pkg::*;

  localparam int unsigned WORDS = STORE_BYTES / 2;
  localparam int AW    = $clog2(WORDS);
  localparam int SHIFT = 2 * OFFSET_W;
  localparam int MW    = SHIFT + 1 - $clog2(STORE_BYTES);
  localparam int QW    = OFFSET_W + 1 - $clog2(STORE_BYTES);
  localparam int RW    = OFFSET_W + 1;
  localparam logic [MW-1:0] RECIP   = MW'((64'd1 << SHIFT) / STORE_BYTES);
  localparam logic [RW-1:0] MODULUS = RW'(STORE_BYTES);
  localparam logic [RW-1:0] WORDS_R = RW'(WORDS);

  logic                 v1_q, v2_q, v3_q;
  logic [OFFSET_W-1:0]  off1_q;
  logic [QW-1:0]        q1_q;
  logic [RW-1:0]        rem_q;
  logic [AW-1:0]        idx_q;
  logic [OFFSET_W+MW-1:0] prod1;
  logic [QW+RW-1:0]     prod2;
  logic [RW-1:0]        rem_d;
  logic [RW-1:0]        r_fix;
  logic [RW-1:0]        w_half;
  logic [RW-1:0]        w_fix;

  assign prod1 = {{MW{1'b0}}, off_i} * {{OFFSET_W{1'b0}}, RECIP};
  assign prod2 = {{RW{1'b0}}, q1_q} * {{QW{1'b0}}, MODULUS};
  assign rem_d = RW'(off1_q) - prod2[RW-1:0];

  assign r_fix  = (rem_q >= MODULUS) ? rem_q - MODULUS : rem_q;
  assign w_half = r_fix >> 1;
  assign w_fix  = (w_half >= WORDS_R) ? w_half - WORDS_R : w_half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      off1_q <= off_i;
      q1_q   <= prod1[SHIFT +: QW];
    end
    if (v1_q) begin
      rem_q <= rem_d;
    end
    if (v2_q) begin
      idx_q <= w_fix[AW-1:0];
    end
  end

  assign done_o = v3_q;
  assign idx_o  = idx_q;

endmodule

`default_nettype wire

@@ hdl/fnbs_store.sv @@
`default_nettype none

module fnbs_store #(
  parameter int unsigned STORE_BYTES = 131072
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [$clog2(STORE_BYTES/2)-1:0] rd_addr_i,
  output logic [15:0]                      rd_data_o,
  input  logic                             wr_en_i,
  input  logic [$clog2(STORE_BYTES/2)-1:0] wr_addr_i,
  input  logic [15:0]                      wr_data_i,
  output logic                             busy_o
);
  import fnbs_pkg::*;

  localparam int unsigned WORDS = STORE_BYTES / 2;
  localparam int AW = $clog2(WORDS);
  localparam logic [AW-1:0] LAST = AW'(WORDS - 1);

  logic [15:0]   mem_q [WORDS];
  logic [15:0]   rd_data_q;
  logic [AW-1:0] clr_cnt_q;
  logic          busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      if (clr_cnt_q == LAST) begin
        busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_cnt_q] <= ERASED_WORD;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

`default_nettype wire

@@ hdl/fnbs_ctrl.sv @@
`default_nettype none

module fnbs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            commit_i,
  input  fnbs_pkg::req_t  req_i,
  output fnbs_pkg::resp_t resp_o
);
  import fnbs_pkg::*;

  cmd_mode_e   cmd_q, cmd_d;
  phase_e      phase_q, phase_d;
  logic        probe_q, probe_d;
  logic [23:0] addr;
  logic [15:0] data;
  logic        in_window;
  logic        hit_one;
  logic        hit_two;

  assign addr      = {req_i.addr[23:1], 1'b0};
  assign data      = req_i.is_byte ? {8'h00, req_i.data[7:0]} : req_i.data;
  assign in_window = (addr[23:20] == DATA_PAGE);
  assign hit_one   = (addr == CMD_ADDR_ONE);
  assign hit_two   = (addr == CMD_ADDR_TWO);

  always_comb begin
    resp_o           = '0;
    resp_o.in_window = in_window;
    resp_o.wdata     = data;
    if (!req_i.is_write) begin
      if (in_window) begin
        resp_o.claimed = 1'b1;
      end else if (probe_q && hit_two) begin
        resp_o.claimed = 1'b1;
        resp_o.word    = PROBE_WORD;
      end else if (cmd_q == CMD_ID && addr == ID_MANUF_ADDR) begin
        resp_o.claimed = 1'b1;
        resp_o.word    = MANUF_ID;
      end else if (cmd_q == CMD_ID && addr == ID_DEVICE_ADDR) begin
        resp_o.claimed = 1'b1;
        resp_o.word    = DEVICE_ID;
      end
    end else begin
      resp_o.claimed  = in_window || hit_one || hit_two;
      resp_o.store_wr = in_window && (cmd_q == CMD_WREN);
    end
  end

  always_comb begin
    cmd_d   = cmd_q;
    phase_d = phase_q;
    probe_d = probe_q;
    if (commit_i && req_i.is_write && !in_window && (hit_one || hit_two)) begin
      unique case (phase_q)
        PH_AA: begin
          phase_d = (hit_two && data == UNLOCK_SECOND) ? PH_55 : PH_IDLE;
        end
        PH_55: begin
          if (hit_one) begin
            if (data == CMD_CODE_ID) begin
              cmd_d = CMD_ID;
            end else if (data == CMD_CODE_WREN) begin
              cmd_d = CMD_WREN;
            end else begin
              cmd_d = CMD_NONE;
            end
          end
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = (hit_one && data == UNLOCK_FIRST) ? PH_AA : PH_IDLE;
        end
      endcase
      if (hit_two && data == PROBE_WORD) begin
        probe_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_NONE;
      phase_q <= PH_IDLE;
      probe_q <= 1'b0;
    end else begin
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      probe_q <= probe_d;
    end
  end

  a_wren_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_o.store_wr |-> (resp_o.claimed && req_i.is_write))
    else $error("store write outside the data window");

  a_cmd_only_from_55: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_d != cmd_q) |-> (phase_q == PH_55 && commit_i && hit_one))
    else $error("command mode changed outside the command phase");

  a_probe_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe_q |=> probe_q)
    else $error("probe flag dropped");

endmodule

`default_nettype wire
